// ===== hdl/pal_pkg.sv =====
package pal_pkg;

	localparam int CAPACITY_DEF = 128;

	// request kinds
	localparam logic [2:0] KIND_INSERT   = 3'd0;
	localparam logic [2:0] KIND_DELETE   = 3'd1;
	localparam logic [2:0] KIND_LOCATE   = 3'd2;
	localparam logic [2:0] KIND_RETRIEVE = 3'd3;
	localparam logic [2:0] KIND_CLEAR    = 3'd4;

	// result status codes
	localparam logic [2:0] STAT_OK       = 3'd0;
	localparam logic [2:0] STAT_FULL     = 3'd1;
	localparam logic [2:0] STAT_EMPTY    = 3'd2;
	localparam logic [2:0] STAT_BADPOS   = 3'd3;
	localparam logic [2:0] STAT_NOTFOUND = 3'd4;

	typedef struct packed {
		logic [2:0]         status;
		logic [7:0]         found_position;
		logic signed [31:0] read_value;
		logic [7:0]         entry_total;
	} res_t;

endpackage

// ===== hdl/positional_array_list.sv =====
// channel | dir | payload
// s_*     | in  | tuser: kind[2:0]; tdata: position[7:0], value[39:8]
// m_*     | out | tuser: status[2:0];
//         |     | tdata: found_position[7:0], read_value[39:8], entry_total[47:40]
//
// Insert at position p shifts entries p..n (n = entry count) up one place, then writes
// the value (only the write when appending); delete shifts the entries after p down
// (none at the last position); locate scans from the first entry to the first hit.
// The one read and one write port of the list memory set the shift and scan rate.
// Reset clears the count only; memory contents stay undefined, no clear pass.
// The result sits in an output register, so a stalled m side does not hold
// off the next s transfer; the following result waits until that one leaves.
module positional_array_list #(
	parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // position[7:0], value[39:8]
	input  logic [2:0]  s_tuser,   // kind[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // found_position[7:0], read_value[39:8], entry_total[47:40]
	output logic [2:0]  m_tuser    // status[2:0]
);

	localparam int AW = $clog2(CAPACITY);

	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [31:0]   mem_wdata, mem_rdata;

	logic          res_valid, res_ready;
	pal_pkg::res_t res;
	pal_pkg::res_t out_q;
	logic          m_valid_q;

	pal_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.kind     (s_tuser),
		.position (s_tdata[7:0]),
		.value    (s_tdata[39:8]),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	pal_store #(
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign res_ready = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			out_q     <= '0;
		end else if (res_valid && res_ready) begin
			m_valid_q <= 1'b1;
			out_q     <= res;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {out_q.entry_total, out_q.read_value, out_q.found_position};

endmodule

// ===== hdl/pal_store.sv =====
module pal_store #(
	parameter int DEPTH = pal_pkg::CAPACITY_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [31:0]              wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [31:0]              rdata
);

	logic [31:0] mem [DEPTH];
	logic [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/pal_ctrl.sv =====
module pal_ctrl #(
	parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// request side
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [2:0]                  kind,
	input  logic [7:0]                  position,
	input  logic signed [31:0]          value,
	// store port
	output logic                        mem_we,
	output logic [$clog2(CAPACITY)-1:0] mem_waddr,
	output logic [31:0]                 mem_wdata,
	output logic                        mem_re,
	output logic [$clog2(CAPACITY)-1:0] mem_raddr,
	input  logic [31:0]                 mem_rdata,
	// result side
	output logic                        res_valid,
	input  logic                        res_ready,
	output pal_pkg::res_t               res
);

	localparam int AW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = ((CW > 8) ? CW : 8) + 1;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_UP    = 3'd1;
	localparam logic [2:0] S_DOWN  = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_READ  = 3'd4;
	localparam logic [2:0] S_DRAIN = 3'd5;
	localparam logic [2:0] S_WVAL  = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0]    state_q;
	logic [CW-1:0] count_q;
	logic [2:0]    kind_q;
	logic [7:0]    pos_q;
	logic [31:0]   val_q;
	logic [AW-1:0] cur_q;
	logic          issue_q;
	logic          wr_s1;
	logic          cmp_s1;
	logic [AW-1:0] addr_s1;
	logic [2:0]    status_q;
	logic [7:0]    found_q;
	logic [31:0]   rd_q;

	logic [CMPW-1:0] pos_w, cnt_w, cap_w, posq_w, cur_w, adr_w;
	logic            accept, ret_ok;

	assign pos_w  = CMPW'(position);
	assign cnt_w  = CMPW'(count_q);
	assign cap_w  = CMPW'(CAPACITY);
	assign posq_w = CMPW'(pos_q);
	assign cur_w  = CMPW'(cur_q);
	assign adr_w  = CMPW'(addr_s1);

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign ret_ok   = (count_q != '0) && (pos_w != '0) && (pos_w <= cnt_w);

	// one read and one write per cycle; each shift write lands in the cycle after its read
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = AW'(pos_w - CMPW'(1));
		case (state_q)
			S_IDLE: begin
				mem_re = accept && (kind == pal_pkg::KIND_RETRIEVE) && ret_ok;
			end
			S_UP: begin
				mem_re    = 1'b1;
				mem_raddr = cur_q - AW'(1);
			end
			S_DOWN: begin
				mem_re    = 1'b1;
				mem_raddr = cur_q + AW'(1);
			end
			S_SCAN: begin
				mem_re    = issue_q;
				mem_raddr = cur_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_s1;
		mem_wdata = mem_rdata;
		if (wr_s1) begin
			mem_we = 1'b1;
		end else if (state_q == S_WVAL) begin
			mem_we    = 1'b1;
			mem_waddr = AW'(posq_w - CMPW'(1));
			mem_wdata = val_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			kind_q   <= '0;
			pos_q    <= '0;
			val_q    <= '0;
			cur_q    <= '0;
			issue_q  <= 1'b0;
			wr_s1    <= 1'b0;
			cmp_s1   <= 1'b0;
			addr_s1  <= '0;
			status_q <= pal_pkg::STAT_OK;
			found_q  <= '0;
			rd_q     <= '0;
		end else begin
			wr_s1  <= 1'b0;
			cmp_s1 <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						kind_q   <= kind;
						pos_q    <= position;
						val_q    <= value;
						status_q <= pal_pkg::STAT_OK;
						found_q  <= '0;
						rd_q     <= '0;
						state_q  <= S_DONE;
						case (kind)
							pal_pkg::KIND_INSERT: begin
								if (cnt_w >= cap_w) begin
									status_q <= pal_pkg::STAT_FULL;
								end else if (pos_w == '0 || pos_w > cnt_w + CMPW'(1)) begin
									status_q <= pal_pkg::STAT_BADPOS;
								end else if (pos_w == cnt_w + CMPW'(1)) begin
									state_q <= S_WVAL;
								end else begin
									cur_q   <= AW'(count_q);
									state_q <= S_UP;
								end
							end
							pal_pkg::KIND_DELETE: begin
								if (count_q == '0) begin
									status_q <= pal_pkg::STAT_EMPTY;
								end else if (pos_w == '0 || pos_w > cnt_w) begin
									status_q <= pal_pkg::STAT_BADPOS;
								end else if (pos_w == cnt_w) begin
									count_q <= count_q - CW'(1);
								end else begin
									cur_q   <= AW'(pos_w - CMPW'(1));
									state_q <= S_DOWN;
								end
							end
							pal_pkg::KIND_LOCATE: begin
								if (count_q == '0) begin
									status_q <= pal_pkg::STAT_NOTFOUND;
									found_q  <= 8'd1;
								end else begin
									cur_q   <= '0;
									issue_q <= 1'b1;
									state_q <= S_SCAN;
								end
							end
							pal_pkg::KIND_RETRIEVE: begin
								if (count_q == '0) begin
									status_q <= pal_pkg::STAT_EMPTY;
								end else if (!ret_ok) begin
									status_q <= pal_pkg::STAT_BADPOS;
								end else begin
									state_q <= S_READ;
								end
							end
							pal_pkg::KIND_CLEAR: begin
								count_q <= '0;
							end
							default: ;
						endcase
					end
				end
				S_UP: begin
					wr_s1   <= 1'b1;
					addr_s1 <= cur_q;
					if (cur_w == posq_w) begin
						state_q <= S_DRAIN;
					end else begin
						cur_q <= cur_q - AW'(1);
					end
				end
				S_DOWN: begin
					wr_s1   <= 1'b1;
					addr_s1 <= cur_q;
					if (cur_w + CMPW'(2) == cnt_w) begin
						state_q <= S_DRAIN;
					end else begin
						cur_q <= cur_q + AW'(1);
					end
				end
				S_DRAIN: begin
					// last shifted word is written this cycle
					if (kind_q == pal_pkg::KIND_INSERT) begin
						state_q <= S_WVAL;
					end else begin
						count_q <= count_q - CW'(1);
						state_q <= S_DONE;
					end
				end
				S_WVAL: begin
					count_q <= count_q + CW'(1);
					state_q <= S_DONE;
				end
				S_SCAN: begin
					if (issue_q) begin
						cmp_s1  <= 1'b1;
						addr_s1 <= cur_q;
						if (cur_w + CMPW'(1) == cnt_w) begin
							issue_q <= 1'b0;
						end else begin
							cur_q <= cur_q + AW'(1);
						end
					end
					if (cmp_s1) begin
						if (mem_rdata == val_q) begin
							status_q <= pal_pkg::STAT_OK;
							found_q  <= 8'(adr_w + CMPW'(1));
							issue_q  <= 1'b0;
							cmp_s1   <= 1'b0;
							state_q  <= S_DONE;
						end else if (adr_w + CMPW'(1) == cnt_w) begin
							status_q <= pal_pkg::STAT_NOTFOUND;
							found_q  <= 8'(cnt_w + CMPW'(1));
							state_q  <= S_DONE;
						end
					end
				end
				S_READ: begin
					rd_q    <= mem_rdata;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_valid          = (state_q == S_DONE);
	assign res.status         = status_q;
	assign res.found_position = found_q;
	assign res.read_value     = rd_q;
	assign res.entry_total    = 8'(count_q);

endmodule

// ===== hdl/pal_checker.sv =====
module pal_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [2:0]  m_tuser
);

	// held result must not change while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// a request transfer always starts work, so the input is not ready in the cycle after it
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after a request transfer");

	// a miss reports one past the last entry
	a_miss_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == pal_pkg::STAT_NOTFOUND |->
			m_tdata[7:0] == m_tdata[47:40] + 8'd1)
		else $error("miss position is not count plus one");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == pal_pkg::STAT_EMPTY |-> m_tdata[47:40] == 8'd0)
		else $error("empty status with live entries");

	// read data only comes with a successful retrieve
	a_rd_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[39:8] != 32'd0 |->
			m_tuser == pal_pkg::STAT_OK && m_tdata[7:0] == 8'd0)
		else $error("read data on a failed or non-retrieve result");

endmodule

bind positional_array_list pal_checker u_pal_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
